FILE: sv/tcp_payload_pattern_filter_macros.svh
// Assertion helpers used by the top-level filter RTL.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TCP_PAYLOAD_PATTERN_FILTER_MACROS_SVH
`define TCP_PAYLOAD_PATTERN_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tppf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tppf assertion failed");

`endif

FILE: sv/tppf_pkg.sv
`default_nettype none

package tppf_pkg;

    // Sizes of the pattern storage and of the configuration port.
    localparam int PATTERN_BYTES   = 24;
    localparam int PATTERN_MAX_DEF = 24;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO    = 3'd4;

    // Reset value of the inspected protocol (TCP).
    localparam logic [7:0] PROTO_TCP = 8'h06;

    // Fixed byte offsets in the IPv4 header and the TCP data-offset position.
    localparam logic [15:0] OFF_IHL    = 16'd0;
    localparam logic [15:0] OFF_LEN_HI = 16'd2;
    localparam logic [15:0] OFF_LEN_LO = 16'd3;
    localparam logic [15:0] OFF_PROTO  = 16'd9;
    localparam logic [6:0]  DOFF_BASE  = 7'd12;

    // Per-byte status from the header parser to the window matcher.
    typedef struct packed {
        logic payload;
        logic proto_hit;
    } t_parse_ctl;

endpackage

`default_nettype wire

FILE: sv/tppf_cfg_regs.sv
`default_nettype none

module tppf_cfg_regs
    import tppf_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    output logic [PATTERN_BYTES*8-1:0]      o_pattern,
    output logic [LEN_W-1:0]                o_pattern_length,
    output logic [7:0]                      o_inspect_protocol
);

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_mid;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_pat_len;
    logic [7:0]            r_proto;

    // Writes are always taken; an index beyond the register list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_mid  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
            r_proto    <= PROTO_TCP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PAT_MID:  r_pat_mid  <= i_cfg_data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[LEN_W-1:0];
                CFG_PROTO:    r_proto    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Byte 0 of the pattern sits in the least significant bits.
    assign o_pattern          = {r_pat_high, r_pat_mid, r_pat_low};
    assign o_pattern_length   = r_pat_len;
    assign o_inspect_protocol = r_proto;

endmodule

`default_nettype wire

FILE: sv/tppf_parser.sv
`default_nettype none

module tppf_parser
    import tppf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic [7:0] i_inspect_protocol,
    output t_parse_ctl      o_ctl
);

    logic [15:0] r_offset;
    logic [3:0]  r_hdr_words;
    logic [15:0] r_total_len;
    logic [7:0]  r_proto;
    logic [3:0]  r_tcp_words;

    logic [6:0]  doff_at;
    logic [6:0]  payload_start;
    logic [7:0]  n_proto;

    // Position of the TCP data-offset byte and first payload byte.
    assign doff_at       = 7'({r_hdr_words, 2'b00}) + DOFF_BASE;
    assign payload_start = 7'({r_hdr_words, 2'b00}) + 7'({r_tcp_words, 2'b00});

    // A byte is payload only past the data-offset byte and below total length.
    assign o_ctl.payload = (r_offset > 16'(doff_at)) && (r_offset >= 16'(payload_start))
                           && (r_offset < r_total_len);

    // The verdict sees the protocol byte even when it is the last byte.
    assign n_proto         = (r_offset == OFF_PROTO) ? i_byte : r_proto;
    assign o_ctl.proto_hit = (n_proto == i_inspect_protocol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_hdr_words <= '0;
            r_total_len <= '0;
            r_proto     <= '0;
            r_tcp_words <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_offset    <= '0;
                r_hdr_words <= '0;
                r_total_len <= '0;
                r_proto     <= '0;
                r_tcp_words <= '0;
            end else begin
                if (r_offset == OFF_IHL) begin
                    r_hdr_words <= i_byte[3:0];
                end
                if (r_offset == OFF_LEN_HI) begin
                    r_total_len[15:8] <= i_byte;
                end
                if (r_offset == OFF_LEN_LO) begin
                    r_total_len[7:0] <= i_byte;
                end
                r_proto <= n_proto;
                if (r_offset == 16'(doff_at)) begin
                    r_tcp_words <= i_byte[7:4];
                end
                // The offset saturates on oversized packets.
                if (r_offset != 16'hFFFF) begin
                    r_offset <= r_offset + 16'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/tppf_matcher.sv
`default_nettype none

module tppf_matcher
    import tppf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic                       i_last,
    input  wire logic [7:0]                 i_byte,
    input  wire t_parse_ctl                 i_ctl,
    input  wire logic [PATTERN_BYTES*8-1:0] i_pattern,
    input  wire logic [LEN_W-1:0]           i_pattern_length,
    output logic                            o_found
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(PATTERN_MAX);

    logic [7:0]       r_win [PATTERN_MAX];
    logic [7:0]       n_win [PATTERN_MAX];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_found;
    logic [LEN_W-1:0] len_eff;
    logic             all_eq;
    logic             match;
    logic [LEN_W-1:0] win_idx;

    // Window after this byte shifts in; entry 0 is the newest byte.
    always_comb begin
        n_win[0] = i_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign len_eff = (i_pattern_length > MAX_LEN) ? MAX_LEN : i_pattern_length;
    assign n_count = (r_count == MAX_CNT) ? r_count : r_count + CNT_W'(1);

    // Pattern byte i lines up with window entry len-1-i.
    always_comb begin
        all_eq  = 1'b1;
        win_idx = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LEN_W'(i) < len_eff) begin
                win_idx = len_eff - LEN_W'(i) - LEN_W'(1);
                if (n_win[win_idx[IDX_W-1:0]] != i_pattern[i*8 +: 8]) begin
                    all_eq = 1'b0;
                end
            end
        end
    end

    assign match   = (len_eff != '0) && (LEN_W'(n_count) >= len_eff) && all_eq;
    assign o_found = r_found | (i_ctl.payload & match);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_count <= '0;
                r_found <= 1'b0;
            end else if (i_ctl.payload) begin
                r_count <= n_count;
                r_found <= r_found | match;
            end
        end
    end

    // Window contents beyond the fill count are never compared.
    always_ff @(posedge i_clk) begin
        if (i_fire && i_ctl.payload) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcp_payload_pattern_filter.sv
// IPv4 payload pattern filter.
// The input channel carries one packet byte per transfer, header first, with
// i_last_byte marking the final byte. For every packet the output channel gives
// exactly one verdict transfer, o_drop_packet, after the marked byte: 1 when the
// packet's protocol equals the inspected protocol and the configured pattern
// occurs in the payload bounded by the IP total length, 0 otherwise.
// The configuration channel writes the pattern words, the pattern length and the
// protocol number; it is always ready and is meant to be used between packets.
// Throughput is one byte per cycle while input ready is high: each byte passes an
// input register, then header tracking and parallel window compare, and the
// verdict lands in an output register.
// When the receiver stalls, the verdict is held and further non-final bytes keep
// flowing; a second final byte waits in the input register until the held
// verdict is taken, and input ready is low only while it waits.
// Reset clears all packet state, sets the pattern length to zero (accept all)
// and the inspected protocol to TCP. No clearing pass is needed.
`default_nettype none

module tcp_payload_pattern_filter
    import tppf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_packet_byte,
    input  wire logic                  i_last_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_drop_packet,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "tcp_payload_pattern_filter_macros.svh"

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_last;
    logic                       r_out_valid;
    logic                       r_out_drop;
    logic                       out_free;
    logic                       proc_fire;
    logic [PATTERN_BYTES*8-1:0] pattern;
    logic [LEN_W-1:0]           pattern_length;
    logic [7:0]                 inspect_protocol;
    t_parse_ctl                 parse_ctl;
    logic                       found;

    // A byte is processed unless it is final and the verdict slot stays full.
    assign out_free   = !r_out_valid || i_out_ready;
    assign proc_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || proc_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_packet_byte;
            r_in_last <= i_last_byte;
        end
    end

    tppf_cfg_regs u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_pattern          (pattern),
        .o_pattern_length   (pattern_length),
        .o_inspect_protocol (inspect_protocol)
    );

    tppf_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (proc_fire),
        .i_byte             (r_in_byte),
        .i_last             (r_in_last),
        .i_inspect_protocol (inspect_protocol),
        .o_ctl              (parse_ctl)
    );

    tppf_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_matcher (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (proc_fire),
        .i_last           (r_in_last),
        .i_byte           (r_in_byte),
        .i_ctl            (parse_ctl),
        .i_pattern        (pattern),
        .i_pattern_length (pattern_length),
        .o_found          (found)
    );

    // Verdict register, loaded by the final byte of each packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in_last) begin
            r_out_drop <= parse_ctl.proto_hit & found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drop_packet = r_out_drop;

    // A processed final byte always produces a verdict in the next cycle.
    `TPPF_ASSERT_NEXT(a_last_makes_verdict, proc_fire && r_in_last, r_out_valid)

    // Non-final bytes never create a verdict.
    `TPPF_ASSERT_NEXT(a_no_spurious_verdict, proc_fire && !r_in_last,
                      r_out_valid == $past(r_out_valid && !i_out_ready))

    // Input back-pressure only comes from a final byte behind a stalled verdict.
    `TPPF_ASSERT_SAME(a_stall_reason, !o_in_ready,
                      r_in_valid && r_in_last && r_out_valid && !i_out_ready)

endmodule

`default_nettype wire
